### hdl/sliding_window_rank_filter_top_defines.svh
// assertion macros for the rank filter checker
`ifndef SLIDING_WINDOW_RANK_FILTER_TOP_DEFINES_SVH
`define SLIDING_WINDOW_RANK_FILTER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle, off during reset
`define SWRF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rank filter check failed");

// antecedent implies consequent in the next cycle, off during reset
`define SWRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rank filter check failed");

// checked during reset as well
`define SWRF_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("rank filter reset check failed");

`endif

### hdl/swrf_pkg.sv
// shared types and constants of the rank filter
package swrf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_WINDOW = 7;
    localparam int MAX_ROWS   = 4096;
    localparam int LINES      = MAX_WINDOW - 1;
    localparam int CELLS      = MAX_WINDOW * MAX_WINDOW;

    localparam int COL_W   = 10;
    localparam int ROW_W   = 12;
    localparam int CHAN_W  = 8;
    localparam int PIX_W   = 3 * CHAN_W;
    localparam int KEY_W   = 10;
    localparam int POS_W   = $clog2(CELLS);
    localparam int LW_W    = 11;
    localparam int SIZE_W  = 3;
    localparam int RANK_W  = 6;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W   = $clog2(CELLS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH  = 2'd0,
        CFG_WINDOW_SIZE = 2'd1,
        CFG_RANK_INDEX  = 2'd2,
        CFG_COLOUR_MODE = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_LOAD,
        ST_COUNT,
        ST_MARK,
        ST_SELECT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              frame_start;
        logic [CHAN_W-1:0] chan_a;
        logic [CHAN_W-1:0] chan_b;
        logic [CHAN_W-1:0] chan_c;
    } in_t;

    typedef struct packed {
        logic [COL_W-1:0]  out_col;
        logic [ROW_W-1:0]  out_row;
        logic [CHAN_W-1:0] res_a;
        logic [CHAN_W-1:0] res_b;
        logic [CHAN_W-1:0] res_c;
    } out_t;

    typedef struct packed {
        logic load;
        logic count;
        logic mark;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
    } stream_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             hit;
    } cand_t;

endpackage

### hdl/sliding_window_rank_filter_top.sv
// rank order filter top level: line stores, window and ranking cells
//
// s_ channel takes one pixel per transfer in raster order; frame_start marks
// the first pixel of a frame. m_ channel gives the selected pixel of each full
// window with the window's top-left column and row. Pixels that do not close
// a full window produce no result.
// cfg_we writes register cfg_index (0 line width, 1 window size, 2 rank,
// 3 colour mode) from cfg_data; write only while the block is idle.
// One pixel is handled at a time. A pixel with no result goes through the shift
// state and back to idle, where s_ready is raised. A pixel with a result is
// loaded into the ranking cell row, which is swept once to count and, after a
// mark step, once to shift the chosen pixel out. The result register frees the
// core, so the next pixel is taken while a result waits; if m_ready stays low
// the block holds the following result and keeps s_ready low until it moves.
// Reset clears the counters, the window, the output and the registers to
// 640, 3, 5, grey. Line stores are not cleared; they fill during the first
// rows of a frame, before any window that uses them is complete.
module sliding_window_rank_filter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  swrf_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output swrf_pkg::out_t                    m_data,
    input  logic                              cfg_we,
    input  logic [swrf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swrf_pkg::CFG_W-1:0]        cfg_data
);

    localparam int NW = swrf_pkg::MAX_WINDOW;
    localparam int NC = swrf_pkg::CELLS;

    logic [swrf_pkg::LW_W-1:0]   lw_reg;
    logic [swrf_pkg::SIZE_W-1:0] ws_reg;
    logic [swrf_pkg::RANK_W-1:0] rank_reg;
    logic                        colour_reg;

    swrf_pkg::state_t state_reg, state_next;

    logic [swrf_pkg::COL_W-1:0] col_reg, cur_col_reg;
    logic [swrf_pkg::ROW_W-1:0] row_reg, cur_row_reg;
    logic [swrf_pkg::PIX_W-1:0] pix_reg, sel_reg;
    logic                       emit_reg;
    logic [swrf_pkg::COL_W-1:0] ocol_reg;
    logic [swrf_pkg::ROW_W-1:0] orow_reg;
    logic [swrf_pkg::CNT_W-1:0] cnt_reg;
    logic                       m_valid_reg;
    swrf_pkg::out_t             m_data_reg;
    logic [swrf_pkg::PIX_W-1:0] win_reg [NC];

    logic [swrf_pkg::LW_W-1:0]   width_eff;
    logic [swrf_pkg::SIZE_W-1:0] size_eff;
    logic [swrf_pkg::RANK_W-1:0] rank_eff, sq, target;
    logic [swrf_pkg::COL_W-1:0]  fc, acol;
    logic [swrf_pkg::ROW_W-1:0]  fr, arow;
    logic [swrf_pkg::LW_W-1:0]   ncol;
    logic                        accept;
    logic                        last_cnt;
    swrf_pkg::cell_ctrl_t        ctrl;

    logic [swrf_pkg::PIX_W-1:0] line_rd [swrf_pkg::LINES];
    logic [swrf_pkg::PIX_W-1:0] column  [NW];

    swrf_pkg::stream_t stream_q [NC];
    swrf_pkg::cand_t   cand_q   [NC];

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_reg     <= swrf_pkg::LW_W'(640);
            ws_reg     <= swrf_pkg::SIZE_W'(3);
            rank_reg   <= swrf_pkg::RANK_W'(5);
            colour_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (swrf_pkg::cfg_idx_t'(cfg_index))
                swrf_pkg::CFG_LINE_WIDTH:  lw_reg     <= cfg_data[swrf_pkg::LW_W-1:0];
                swrf_pkg::CFG_WINDOW_SIZE: ws_reg     <= cfg_data[swrf_pkg::SIZE_W-1:0];
                swrf_pkg::CFG_RANK_INDEX:  rank_reg   <= cfg_data[swrf_pkg::RANK_W-1:0];
                swrf_pkg::CFG_COLOUR_MODE: colour_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // register clamps
    always_comb begin
        if (lw_reg == '0) begin
            width_eff = swrf_pkg::LW_W'(1);
        end else if (lw_reg > swrf_pkg::LW_W'(swrf_pkg::MAX_WIDTH)) begin
            width_eff = swrf_pkg::LW_W'(swrf_pkg::MAX_WIDTH);
        end else begin
            width_eff = lw_reg;
        end
        if (ws_reg == '0) begin
            size_eff = swrf_pkg::SIZE_W'(1);
        end else if (ws_reg > swrf_pkg::SIZE_W'(NW)) begin
            size_eff = swrf_pkg::SIZE_W'(NW);
        end else begin
            size_eff = ws_reg;
        end
        sq = swrf_pkg::RANK_W'(size_eff) * swrf_pkg::RANK_W'(size_eff);
        rank_eff = (rank_reg == '0) ? swrf_pkg::RANK_W'(1) : rank_reg;
        if (rank_eff > sq) begin
            rank_eff = sq;
        end
        target = rank_eff - 1'b1;
    end

    // position of the incoming pixel
    always_comb begin
        fc = s_data.frame_start ? '0 : col_reg;
        fr = s_data.frame_start ? '0 : row_reg;
        if (swrf_pkg::LW_W'(fc) >= width_eff) begin
            acol = '0;
            arow = (fr == swrf_pkg::ROW_W'(swrf_pkg::MAX_ROWS - 1)) ? fr : fr + 1'b1;
        end else begin
            acol = fc;
            arow = fr;
        end
        ncol = swrf_pkg::LW_W'(cur_col_reg) + 1'b1;
    end

    assign accept   = s_valid && s_ready;
    assign last_cnt = (cnt_reg == swrf_pkg::CNT_W'(NC - 1));

    // line stores
    genvar k;
    generate
        for (k = 0; k < swrf_pkg::LINES; k++) begin : g_line
            swrf_ram #(
                .WIDTH(swrf_pkg::PIX_W),
                .DEPTH(swrf_pkg::MAX_WIDTH)
            ) u_line (
                .aclk (aclk),
                .we   (state_reg == swrf_pkg::ST_SHIFT),
                .waddr(cur_col_reg),
                .wdata(column[k]),
                .raddr(acol),
                .rdata(line_rd[k])
            );
        end
    endgenerate

    always_comb begin
        column[0] = pix_reg;
        for (int i = 1; i < NW; i++) begin
            column[i] = line_rd[i-1];
        end
    end

    // state machine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= swrf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            swrf_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = swrf_pkg::ST_SHIFT;
                end
            end
            swrf_pkg::ST_SHIFT: begin
                state_next = emit_reg ? swrf_pkg::ST_LOAD : swrf_pkg::ST_IDLE;
            end
            swrf_pkg::ST_LOAD: begin
                ctrl.load  = 1'b1;
                state_next = swrf_pkg::ST_COUNT;
            end
            swrf_pkg::ST_COUNT: begin
                ctrl.count = 1'b1;
                if (last_cnt) begin
                    state_next = swrf_pkg::ST_MARK;
                end
            end
            swrf_pkg::ST_MARK: begin
                ctrl.mark  = 1'b1;
                state_next = swrf_pkg::ST_SELECT;
            end
            swrf_pkg::ST_SELECT: begin
                ctrl.shift = 1'b1;
                if (last_cnt) begin
                    state_next = swrf_pkg::ST_OUT;
                end
            end
            swrf_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = swrf_pkg::ST_IDLE;
                end
            end
            default: state_next = swrf_pkg::ST_IDLE;
        endcase
    end

    // counters and item registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (state_reg == swrf_pkg::ST_SHIFT) begin
                if (ncol >= width_eff) begin
                    col_reg <= '0;
                    row_reg <= (cur_row_reg == swrf_pkg::ROW_W'(swrf_pkg::MAX_ROWS - 1))
                        ? cur_row_reg : cur_row_reg + 1'b1;
                end else begin
                    col_reg <= ncol[swrf_pkg::COL_W-1:0];
                    row_reg <= cur_row_reg;
                end
            end
            if ((state_reg == swrf_pkg::ST_COUNT) || (state_reg == swrf_pkg::ST_SELECT)) begin
                cnt_reg <= last_cnt ? '0 : cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_col_reg <= acol;
            cur_row_reg <= arow;
            pix_reg     <= {s_data.chan_c, s_data.chan_b, s_data.chan_a};
            emit_reg    <= ((swrf_pkg::LW_W'(acol) + 1'b1) >= swrf_pkg::LW_W'(size_eff)) &&
                           ((13'(arow) + 1'b1) >= 13'(size_eff));
            ocol_reg    <= acol + 1'b1 - swrf_pkg::COL_W'(size_eff);
            orow_reg    <= arow + 1'b1 - swrf_pkg::ROW_W'(size_eff);
        end
        if ((state_reg == swrf_pkg::ST_SELECT) && cand_q[0].hit) begin
            sel_reg <= cand_q[0].pix;
        end
    end

    // window shift row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < NC; p++) begin
                win_reg[p] <= '0;
            end
        end else if (state_reg == swrf_pkg::ST_SHIFT) begin
            for (int p = 0; p < NC; p++) begin
                if ((p % NW) == 0) begin
                    win_reg[p] <= column[p / NW];
                end else begin
                    win_reg[p] <= win_reg[p-1];
                end
            end
        end
    end

    // ranking cells
    genvar p;
    generate
        for (p = 0; p < NC; p++) begin : g_cell
            localparam int DY = p / NW;
            localparam int DX = p % NW;
            logic            in_win;
            swrf_pkg::cand_t cand_next;

            assign in_win    = (DY < int'(size_eff)) && (DX < int'(size_eff));
            assign cand_next = (p == NC - 1) ? '0 : cand_q[(p + 1) % NC];

            swrf_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .colour    (colour_reg),
                .pos       (swrf_pkg::POS_W'(p)),
                .win_pix   (win_reg[p]),
                .win_valid (in_win),
                .target    (target),
                .bcast     (stream_q[0]),
                .stream_in (stream_q[(p + 1) % NC]),
                .stream_out(stream_q[p]),
                .cand_in   (cand_next),
                .cand_out  (cand_q[p])
            );
        end
    endgenerate

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == swrf_pkg::ST_OUT) && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == swrf_pkg::ST_OUT) && (!m_valid_reg || m_ready)) begin
            m_data_reg.out_col <= ocol_reg;
            m_data_reg.out_row <= orow_reg;
            m_data_reg.res_a   <= sel_reg[7:0];
            m_data_reg.res_b   <= colour_reg ? sel_reg[15:8] : '0;
            m_data_reg.res_c   <= colour_reg ? sel_reg[23:16] : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hdl/swrf_ram.sv
// generic single port write, registered read ram
module swrf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/swrf_cell.sv
// one ranking cell: holds a candidate, counts smaller entries passing by
module swrf_cell (
    input  logic                          aclk,
    input  swrf_pkg::cell_ctrl_t          ctrl,
    input  logic                          colour,
    input  logic [swrf_pkg::POS_W-1:0]    pos,
    input  logic [swrf_pkg::PIX_W-1:0]    win_pix,
    input  logic                          win_valid,
    input  logic [swrf_pkg::RANK_W-1:0]   target,
    input  swrf_pkg::stream_t             bcast,
    input  swrf_pkg::stream_t             stream_in,
    output swrf_pkg::stream_t             stream_out,
    input  swrf_pkg::cand_t               cand_in,
    output swrf_pkg::cand_t               cand_out
);

    logic [swrf_pkg::KEY_W-1:0] key;
    logic [swrf_pkg::KEY_W-1:0] key_reg;
    logic                       valid_reg;
    logic [swrf_pkg::CNT_W-1:0] count_reg;
    swrf_pkg::stream_t          stream_reg;
    swrf_pkg::cand_t            cand_reg;
    logic                       smaller;

    always_comb begin
        if (colour) begin
            key = swrf_pkg::KEY_W'(win_pix[7:0]) + swrf_pkg::KEY_W'(win_pix[15:8])
                + swrf_pkg::KEY_W'(win_pix[23:16]);
        end else begin
            key = swrf_pkg::KEY_W'(win_pix[7:0]);
        end
    end

    // earlier raster position sits at a higher cell index
    assign smaller = bcast.valid &&
        ((bcast.key < key_reg) || ((bcast.key == key_reg) && (bcast.pos > pos)));

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            key_reg          <= key;
            valid_reg        <= win_valid;
            count_reg        <= '0;
            stream_reg.valid <= win_valid;
            stream_reg.key   <= key;
            stream_reg.pos   <= pos;
            cand_reg.pix     <= win_pix;
            cand_reg.hit     <= 1'b0;
        end else if (ctrl.count) begin
            stream_reg <= stream_in;
            if (smaller) begin
                count_reg <= count_reg + 1'b1;
            end
        end else if (ctrl.mark) begin
            cand_reg.hit <= valid_reg && (count_reg == target);
        end else if (ctrl.shift) begin
            cand_reg <= cand_in;
        end
    end

    assign stream_out = stream_reg;
    assign cand_out   = cand_reg;

endmodule

### hdl/swrf_checker.sv
// port level checks of the rank filter, bound to the top level
`include "sliding_window_rank_filter_top_defines.svh"

module swrf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input swrf_pkg::out_t                 m_data,
    input logic                           cfg_we,
    input logic [swrf_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [swrf_pkg::CFG_W-1:0]     cfg_data
);

    logic s_xfer;
    logic m_stall;

    assign s_xfer  = s_valid && s_ready;
    assign m_stall = m_valid && !m_ready;

    `SWRF_ASSERT_NEXT(a_busy_after_xfer, s_xfer, !s_ready)
    `SWRF_ASSERT_NEXT(a_result_held, m_stall, m_valid && $stable(m_data))
    `SWRF_ASSERT_SAME(a_result_from_work, m_valid && !$past(m_valid), !$past(s_ready))
    `SWRF_ASSERT_RST(a_reset_clears, !aresetn, !m_valid)
    `SWRF_ASSERT_SAME(a_cfg_when_idle, cfg_we, s_ready && !m_valid && !$isunknown({cfg_index, cfg_data}))

endmodule

bind sliding_window_rank_filter_top swrf_checker u_swrf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_data   (m_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
);
